### sv/debounce_timer_allocator_unit_defines.svh
// Assertion helpers for the debounce timer allocator.
`ifndef DEBOUNCE_TIMER_ALLOCATOR_UNIT_DEFINES_SVH
`define DEBOUNCE_TIMER_ALLOCATOR_UNIT_DEFINES_SVH

// Condition implies a property in the same cycle.
`define DTA_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("debounce timer allocator check failed");

// Condition implies a property in the next cycle.
`define DTA_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("debounce timer allocator check failed");

`endif

### sv/dta_pkg.sv
package dta_pkg;

  localparam int NUM_PINS_DEF   = 256;
  localparam int NUM_TIMERS_DEF = 4;

  // Microseconds per second; the divisor of the cycle conversion.
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  localparam logic [31:0] U32_MAX    = 32'hFFFF_FFFF;

  // The remainder left by the reciprocal estimate stays below five times the divisor.
  localparam int REM_W = 23;

  // Products at or above this limit give a quotient of U32_MAX or more.
  localparam logic [63:0] PROD_LIMIT = 64'(U32_MAX) * 64'(US_PER_SEC);

  // Reciprocal of the divisor scaled by 2^51, applied to the product shifted right by 20.
  localparam logic [31:0] RECIP_M = 32'((64'd1 << 51) / 64'(US_PER_SEC));

  typedef logic [1:0] status_t;

  localparam status_t STAT_OK        = 2'd0;
  localparam status_t STAT_INVALID   = 2'd1;
  localparam status_t STAT_RANGE     = 2'd2;
  localparam status_t STAT_EXHAUSTED = 2'd3;

endpackage

### sv/debounce_timer_allocator_unit.sv
// Debounce timer allocator. Each request names a pin and a period in microseconds and returns
// one result: a status, the timer now selected for the pin, and whether a free timer was loaded
// with a new cycle count. After reset the pin table is cleared one entry per cycle, and the input
// stays closed until every entry is cleared (configuration writes are taken throughout). A
// request first reads the pin table. It ends there if the pin is out of range or no clock is
// set, ends after a release step if the period is zero, and ends after the product if the period
// is out of range. Otherwise one shared 32x32 multiplier forms the product, a reciprocal estimate
// of the quotient by one million and its remainder, the estimate is corrected by compare and
// subtract, the old timer is released, and the timers are then scanned one per cycle, first
// for a matching period and then for a free timer. One request is in flight at a time;
// in_ready is high only while the block is idle.
module debounce_timer_allocator_unit #(
  parameter int NUM_PINS   = dta_pkg::NUM_PINS_DEF,
  parameter int NUM_TIMERS = dta_pkg::NUM_TIMERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [31:0]                     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_pin,
  input  logic [31:0]                     in_period_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dta_pkg::status_t                out_status,
  output logic [$clog2(NUM_TIMERS)-1:0]   out_timer_select,
  output logic                            out_load_timer,
  output logic [31:0]                     out_load_value
);
  import dta_pkg::*;

  `include "debounce_timer_allocator_unit_defines.svh"

  localparam int PW = $clog2(NUM_PINS);
  localparam int TW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_PINS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_REL   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_RECIP = 4'd6;
  localparam logic [3:0] S_BACK  = 4'd7;
  localparam logic [3:0] S_FIX   = 4'd8;
  localparam logic [3:0] S_QCHK  = 4'd9;
  localparam logic [3:0] S_MATCH = 4'd10;
  localparam logic [3:0] S_FREE  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [31:0]   clock_rate_r, clock_rate_nxt;
  logic [PW-1:0] pin_idx_r, pin_idx_nxt;
  logic          pin_ok_r, pin_ok_nxt;
  logic [31:0]   usecs_r, usecs_nxt;
  logic [TW-1:0] old_t_r, old_t_nxt;
  logic [TW-1:0] t_idx_r, t_idx_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [31:0]   cycles_r, cycles_nxt;
  logic [CW-1:0] cnt_r [NUM_TIMERS];
  logic [CW-1:0] cnt_nxt [NUM_TIMERS];
  logic [31:0]   period_r [NUM_TIMERS];
  logic [31:0]   period_nxt [NUM_TIMERS];

  status_t       out_status_r, out_status_nxt;
  logic [TW-1:0] out_sel_r, out_sel_nxt;
  logic          out_load_r, out_load_nxt;
  logic [31:0]   out_value_r, out_value_nxt;

  logic [TW-1:0] pin_timer_mem [NUM_PINS];
  logic [TW-1:0] rd_data_r;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [TW-1:0] mem_wdata;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   mul_p;
  logic          last_timer;
  logic          q_ovf;
  logic          rem_big;

  assign mul_p      = 64'(mul_a) * 64'(mul_b);
  assign last_timer = (t_idx_r == TW'(NUM_TIMERS - 1));
  assign q_ovf      = (prod_r >= PROD_LIMIT);
  assign rem_big    = (rem_r >= REM_W'(US_PER_SEC));

  // The one multiplier forms the product, the reciprocal estimate of the quotient and the
  // quotient times the divisor, in that order.
  always_comb begin
    case (state_r)
      S_RECIP: begin
        mul_a = prod_r[51:20];
        mul_b = RECIP_M;
      end
      S_BACK: begin
        mul_a = q_r;
        mul_b = 32'(US_PER_SEC);
      end
      default: begin
        mul_a = clock_rate_r;
        mul_b = usecs_r;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clock_rate_nxt = cfg_wr_en ? cfg_wr_data : clock_rate_r;
    pin_idx_nxt    = pin_idx_r;
    pin_ok_nxt     = pin_ok_r;
    usecs_nxt      = usecs_r;
    old_t_nxt      = old_t_r;
    t_idx_nxt      = t_idx_r;
    prod_nxt       = prod_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    cycles_nxt     = cycles_r;
    cnt_nxt        = cnt_r;
    period_nxt     = period_r;
    out_status_nxt = out_status_r;
    out_sel_nxt    = out_sel_r;
    out_load_nxt   = out_load_r;
    out_value_nxt  = out_value_r;
    mem_we         = 1'b0;
    mem_waddr      = pin_idx_r;
    mem_wdata      = '0;

    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        if (clr_cnt_r == PW'(NUM_PINS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          pin_idx_nxt = PW'(in_pin);
          pin_ok_nxt  = (32'(in_pin) < 32'(NUM_PINS));
          usecs_nxt   = in_period_us;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        old_t_nxt     = rd_data_r;
        t_idx_nxt     = rd_data_r;
        out_load_nxt  = 1'b0;
        out_value_nxt = 32'd0;
        if (!pin_ok_r) begin
          out_status_nxt = STAT_INVALID;
          out_sel_nxt    = '0;
          state_nxt      = S_DONE;
        end else if (usecs_r == 32'd0) begin
          state_nxt = S_REL;
        end else if (clock_rate_r == 32'd0) begin
          out_status_nxt = STAT_INVALID;
          out_sel_nxt    = rd_data_r;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_REL: begin
        state_nxt = S_DONE;
        if (old_t_r == '0 || cnt_r[t_idx_r] == '0) begin
          out_status_nxt = STAT_INVALID;
          out_sel_nxt    = old_t_r;
        end else begin
          cnt_nxt[t_idx_r] = cnt_r[t_idx_r] - 1'b1;
          mem_we           = 1'b1;
          out_status_nxt   = STAT_OK;
          out_sel_nxt      = '0;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_RECIP;
      end
      S_RECIP: begin
        if (q_ovf) begin
          out_status_nxt = STAT_RANGE;
          out_sel_nxt    = old_t_r;
          state_nxt      = S_DONE;
        end else begin
          q_nxt     = mul_p[62:31];
          state_nxt = S_BACK;
        end
      end
      S_BACK: begin
        rem_nxt   = REM_W'(prod_r - mul_p);
        state_nxt = S_FIX;
      end
      S_FIX: begin
        // The estimate is never high and at most four low.
        if (rem_big) begin
          rem_nxt = rem_r - REM_W'(US_PER_SEC);
          q_nxt   = q_r + 32'd1;
        end else begin
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        cycles_nxt = q_r + 32'(rem_r != '0);
        if (old_t_r != '0 && cnt_r[t_idx_r] == '0) begin
          // The pin holds a timer that nobody counts as a user.
          out_status_nxt = STAT_INVALID;
          out_sel_nxt    = old_t_r;
          state_nxt      = S_DONE;
        end else begin
          if (old_t_r != '0) begin
            cnt_nxt[t_idx_r] = cnt_r[t_idx_r] - 1'b1;
            mem_we           = 1'b1;
          end
          t_idx_nxt = TW'(1);
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        if (period_r[t_idx_r] == cycles_r) begin
          cnt_nxt[t_idx_r] = cnt_r[t_idx_r] + 1'b1;
          mem_we           = 1'b1;
          mem_wdata        = t_idx_r;
          out_status_nxt   = STAT_OK;
          out_sel_nxt      = t_idx_r;
          state_nxt        = S_DONE;
        end else if (last_timer) begin
          t_idx_nxt = TW'(1);
          state_nxt = S_FREE;
        end else begin
          t_idx_nxt = t_idx_r + 1'b1;
        end
      end
      S_FREE: begin
        if (cnt_r[t_idx_r] == '0) begin
          cnt_nxt[t_idx_r]    = cnt_r[t_idx_r] + 1'b1;
          period_nxt[t_idx_r] = cycles_r;
          mem_we              = 1'b1;
          mem_wdata           = t_idx_r;
          out_status_nxt      = STAT_OK;
          out_sel_nxt         = t_idx_r;
          out_load_nxt        = 1'b1;
          out_value_nxt       = cycles_r;
          state_nxt           = S_DONE;
        end else if (last_timer) begin
          out_status_nxt = STAT_EXHAUSTED;
          out_sel_nxt    = '0;
          state_nxt      = S_DONE;
        end else begin
          t_idx_nxt = t_idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      clock_rate_r <= 32'd0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cnt_r[i]    <= '0;
        period_r[i] <= 32'd0;
      end
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clock_rate_r <= clock_rate_nxt;
      cnt_r        <= cnt_nxt;
      period_r     <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pin_idx_r    <= pin_idx_nxt;
    pin_ok_r     <= pin_ok_nxt;
    usecs_r      <= usecs_nxt;
    old_t_r      <= old_t_nxt;
    t_idx_r      <= t_idx_nxt;
    prod_r       <= prod_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    cycles_r     <= cycles_nxt;
    out_status_r <= out_status_nxt;
    out_sel_r    <= out_sel_nxt;
    out_load_r   <= out_load_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pin_timer_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= pin_timer_mem[pin_idx_r];
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = (state_r == S_DONE);
  assign out_status       = out_status_r;
  assign out_timer_select = out_sel_r;
  assign out_load_timer   = out_load_r;
  assign out_load_value   = out_value_r;

  `DTA_ASSERT_NOW(a_load_is_ok, out_valid && out_load_timer, out_status == STAT_OK && out_load_value != 32'd0 && out_timer_select != '0)
  `DTA_ASSERT_NOW(a_exhausted_no_sel, out_valid && out_status == STAT_EXHAUSTED, out_timer_select == '0 && !out_load_timer)
  `DTA_ASSERT_NOW(a_sel_has_user, out_valid && out_status == STAT_OK && out_timer_select != '0, cnt_r[out_timer_select] != '0)
  `DTA_ASSERT_NEXT(a_clear_blocks_input, state_r == S_CLR && clr_cnt_r != PW'(NUM_PINS - 1), !in_ready)

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dta_pkg::*;

  localparam int NUM_PINS    = NUM_PINS_DEF;
  localparam int NUM_TIMERS  = NUM_TIMERS_DEF;
  localparam int SEL_W       = $clog2(NUM_TIMERS);
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [7:0]  pin;
    logic [31:0] period_us;
  } debounce_req_t;

  typedef struct {
    status_t            status;
    logic [SEL_W-1:0]   timer_select;
    logic               load_timer;
    logic [31:0]        load_value;
  } timer_grant_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [31:0]       cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_pin = '0;
  logic [31:0]       in_period_us = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  status_t           out_status;
  logic [SEL_W-1:0]  out_timer_select;
  logic              out_load_timer;
  logic [31:0]       out_load_value;

  // Shadow copy of the allocator state.
  logic [SEL_W-1:0]  pin_owner [NUM_PINS];
  int unsigned       timer_refs [NUM_TIMERS];
  logic [31:0]       timer_cycles [NUM_TIMERS];
  logic [31:0]       clock_hz;

  debounce_req_t     pending_requests[$];
  timer_grant_t      expected_grants[$];
  debounce_req_t     next_req;
  timer_grant_t      got_grant;
  timer_grant_t      want_grant;
  int unsigned       sender_idle_pct = 25;
  int unsigned       receiver_idle_pct = 57;
  int unsigned       mismatches = 0;
  int unsigned       stall_cycles = 0;

  debounce_timer_allocator_unit #(
    .NUM_PINS   (NUM_PINS),
    .NUM_TIMERS (NUM_TIMERS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin           (in_pin),
    .in_period_us     (in_period_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_timer_select (out_timer_select),
    .out_load_timer   (out_load_timer),
    .out_load_value   (out_load_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int p = 0; p < NUM_PINS; p++) pin_owner[p] = '0;
    for (int t = 0; t < NUM_TIMERS; t++) begin
      timer_refs[t] = 0;
      timer_cycles[t] = '0;
    end
    clock_hz = '0;
  end

  function automatic bit release_pin(input int unsigned pin);
    int unsigned owner;
    owner = 32'(pin_owner[pin]);
    if (owner == 0 || owner >= NUM_TIMERS || timer_refs[owner] == 0) return 1'b0;
    timer_refs[owner]--;
    pin_owner[pin] = '0;
    return 1'b1;
  endfunction

  function automatic timer_grant_t predict_grant(input logic [7:0] pin, input logic [31:0] us);
    timer_grant_t res;
    logic [63:0]  prod;
    logic [63:0]  quot;
    logic [63:0]  rem;
    logic [31:0]  cycles;
    int unsigned  found;
    res = '{STAT_OK, '0, 1'b0, 32'd0};
    found = 0;
    if (int'(pin) >= NUM_PINS) begin
      res.status = STAT_INVALID;
    end else if (us == 32'd0) begin
      res.status = release_pin(32'(pin)) ? STAT_OK : STAT_INVALID;
      res.timer_select = pin_owner[pin];
    end else if (clock_hz == 32'd0) begin
      res.status = STAT_INVALID;
      res.timer_select = pin_owner[pin];
    end else begin
      prod = {32'd0, clock_hz} * {32'd0, us};
      quot = prod / {44'd0, US_PER_SEC};
      rem  = prod % {44'd0, US_PER_SEC};
      if (quot >= {32'd0, U32_MAX}) begin
        res.status = STAT_RANGE;
        res.timer_select = pin_owner[pin];
      end else if (pin_owner[pin] != 0 && !release_pin(32'(pin))) begin
        res.status = STAT_INVALID;
        res.timer_select = pin_owner[pin];
      end else begin
        cycles = quot[31:0] + ((rem != 64'd0) ? 32'd1 : 32'd0);
        for (int t = 1; t < NUM_TIMERS; t++) begin
          if (found == 0 && timer_cycles[t] == cycles) found = t;
        end
        if (found == 0) begin
          for (int t = 1; t < NUM_TIMERS; t++) begin
            if (found == 0 && timer_refs[t] == 0) found = t;
          end
          if (found != 0) begin
            timer_cycles[found] = cycles;
            res.load_timer = 1'b1;
            res.load_value = cycles;
          end
        end
        if (found == 0) begin
          res.status = STAT_EXHAUSTED;
        end else begin
          pin_owner[pin] = SEL_W'(found);
          timer_refs[found]++;
          res.timer_select = SEL_W'(found);
        end
      end
    end
    return res;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_grants.push_back(predict_grant(in_pin, in_period_us));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_pin <= next_req.pin;
          in_period_us <= next_req.period_us;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      mismatches = mismatches + 1;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_grant = '{out_status, out_timer_select, out_load_timer, out_load_value};
        if (expected_grants.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected result, expected none, got status %0d select %0d",
                   $time, got_grant.status, got_grant.timer_select);
        end else begin
          want_grant = expected_grants.pop_front();
          report_field("status", 32'(want_grant.status), 32'(got_grant.status));
          report_field("timer_select", 32'(want_grant.timer_select),
                       32'(got_grant.timer_select));
          report_field("load_timer", 32'(want_grant.load_timer), 32'(got_grant.load_timer));
          report_field("load_value", want_grant.load_value, got_grant.load_value);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: timeout, no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_request(input logic [7:0] pin, input logic [31:0] us);
    pending_requests.push_back('{pin, us});
  endtask

  function automatic logic [31:0] random_period();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return 32'd0;
    if (roll < 60) begin
      case ($urandom_range(0, 5))
        0: return 32'd1;
        1: return 32'd2;
        2: return 32'd10;
        3: return 32'd100;
        4: return 32'd1000;
        default: return 32'd20000;
      endcase
    end
    if (roll < 80) return $urandom_range(1, 5000);
    if (roll < 90) return $urandom;
    case ($urandom_range(0, 2))
      0: return U32_MAX;
      1: return U32_MAX - 32'd1;
      default: return 32'h8000_0000 | $urandom;
    endcase
  endfunction

  // Pins cluster on a few low numbers so that timers get shared and released.
  task automatic queue_random(input int unsigned count);
    logic [7:0] pin;
    repeat (count) begin
      pin = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 15))
                                          : 8'($urandom_range(0, 255));
      queue_request(pin, random_period());
    end
  endtask

  // Checked at the falling edge so that queue updates of the rising edge have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_rate(input logic [31:0] rate);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    clock_hz = rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The clock rate is still zero from reset.
    queue_request(8'd0, 32'd0);
    queue_request(8'd5, 32'd5);
    queue_request(8'd255, U32_MAX);
    queue_random(50);
    wait_drained();

    program_rate(32'd1000000);
    queue_request(8'd0, 32'd1);
    queue_request(8'd255, 32'd1);
    queue_request(8'd1, U32_MAX);
    queue_request(8'd1, U32_MAX - 32'd1);
    queue_request(8'd2, 32'd100);
    queue_request(8'd3, 32'd7);
    queue_request(8'd255, U32_MAX - 32'd1);
    queue_request(8'd0, 32'd0);
    queue_request(8'd0, 32'd0);
    queue_request(8'd3, 32'd7);
    queue_request(8'd2, 32'd100);
    queue_request(8'd2, 32'd0);
    queue_request(8'd128, 32'd0);
    queue_random(240);
    wait_drained();

    sender_idle_pct = 57;
    receiver_idle_pct = 25;
    program_rate(U32_MAX);
    queue_request(8'd4, 32'd1);
    queue_request(8'd4, 32'd999999);
    queue_request(8'd4, 32'd1000000);
    queue_random(200);
    wait_drained();

    program_rate(32'd1);
    queue_random(100);
    wait_drained();
    queue_random(100);
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    program_rate($urandom);
    queue_random(200);
    wait_drained();

    program_rate(32'd0);
    queue_random(80);
    wait_drained();

    program_rate(32'd32768);
    queue_random(60);
    wait_drained();

    repeat (40) @(posedge clk);
    if (expected_grants.size() != 0) begin
      mismatches = mismatches + 1;
      $display("%0t: %0d results never arrived", $time, expected_grants.size());
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/dta_pkg.sv
sv/debounce_timer_allocator_unit.sv
bench/testbench.sv
